// ===== sv/peak_valley_detector_defines.svh =====
// ----------------------------------------------------------------------------
// peak_valley_detector assertion macros
// shared property wrappers for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef PEAK_VALLEY_DETECTOR_DEFINES_SVH
`define PEAK_VALLEY_DETECTOR_DEFINES_SVH

// property must hold at every edge out of reset
`define PVD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// expression must never be true out of reset
`define PVD_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== sv/pvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvd_pkg
// shared constants, codes and defaults of the peak/valley detector
// ----------------------------------------------------------------------------
package pvd_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int FRAC_BITS  = 8;
    localparam int DELTA_W    = 24;
    localparam int LIMIT_W    = 5;
    localparam int KIND_W     = 2;
    localparam int POS_W      = 10;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_DELTA          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_EMISSION_FIRST = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EMISSION   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ABSORPTION = CFG_IDX_W'(3);

    localparam logic [KIND_W-1:0] KIND_EMISSION   = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_ABSORPTION = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_END        = KIND_W'(2);

    localparam logic [STATUS_W-1:0] STATUS_OK             = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMISSION_FULL   = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_ABSORPTION_FULL = STATUS_W'(2);

    localparam logic [DELTA_W-1:0] DELTA_RST          = '0;
    localparam logic               EMISSION_FIRST_RST = 1'b1;
    localparam logic [LIMIT_W-1:0] LIMIT_RST          = '1;

endpackage

// ===== sv/pvd_ram.sv =====
// ----------------------------------------------------------------------------
// pvd_ram
// generic single-write, single-read synchronous ram with registered read data
// ----------------------------------------------------------------------------
module pvd_ram #(
    parameter int WIDTH = pvd_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = pvd_pkg::MAX_SAMPLES_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/peak_valley_detector.sv =====
// ----------------------------------------------------------------------------
// peak_valley_detector
// delta peak and valley detection over a stored sample sequence
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low and go into a sample ram;
// samples beyond MAX_SAMPLES are dropped. A sample with i_last set closes the
// sequence: busy rises and a scan runs over the ram. Each visited sample is
// read from the ram in one step and compared and updated in the next, since
// each step waits on the single read port; after every report the scan
// restarts at the reported position. Each peak or valley appears for one
// cycle under o_strobe in the cycle after the step that finds it, the end
// item (o_is_last, with status) follows last, and busy is low again from the
// cycle that shows the end item. Results cannot be held off. Configuration
// writes are taken while busy is low. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module peak_valley_detector #(
    parameter int MAX_SAMPLES = pvd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pvd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    input  logic                             i_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pvd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pvd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                             o_strobe,
    output logic [pvd_pkg::KIND_W-1:0]       o_kind,
    output logic [pvd_pkg::POS_W-1:0]        o_position,
    output logic [pvd_pkg::STATUS_W-1:0]     o_status,
    output logic                             o_is_last
);

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int S8_W   = SAMPLE_BITS + pvd_pkg::FRAC_BITS;
    localparam int CMP_W  = ((S8_W > pvd_pkg::DELTA_W) ? S8_W : pvd_pkg::DELTA_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_LD0,
        S_CHECK,
        S_EVAL,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [pvd_pkg::DELTA_W-1:0] r_delta;
    logic                        r_emission_first;
    logic [pvd_pkg::LIMIT_W-1:0] r_max_emission;
    logic [pvd_pkg::LIMIT_W-1:0] r_max_absorption;

    logic [CNT_W-1:0]             r_count, n_count;
    logic [CNT_W-1:0]             r_scan, n_scan;
    logic [SAMPLE_BITS-1:0]       r_max, n_max;
    logic [SAMPLE_BITS-1:0]       r_min, n_min;
    logic [ADDR_W-1:0]            r_max_idx, n_max_idx;
    logic [ADDR_W-1:0]            r_min_idx, n_min_idx;
    logic                         r_seeking, n_seeking;
    logic [pvd_pkg::LIMIT_W-1:0]  r_emi_cnt, n_emi_cnt;
    logic [pvd_pkg::LIMIT_W-1:0]  r_abs_cnt, n_abs_cnt;
    logic [pvd_pkg::STATUS_W-1:0] r_run_status, n_run_status;

    logic                         r_strobe, n_strobe;
    logic [pvd_pkg::KIND_W-1:0]   r_kind, n_kind;
    logic [pvd_pkg::POS_W-1:0]    r_position, n_position;
    logic [pvd_pkg::STATUS_W-1:0] r_status, n_status;
    logic                         r_is_last, n_is_last;

    logic                   accept;
    logic                   room;
    logic                   ram_we;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    logic [SAMPLE_BITS-1:0] s_val;
    logic [SAMPLE_BITS-1:0] upd_max, upd_min;
    logic [ADDR_W-1:0]      upd_max_idx, upd_min_idx;
    logic [CMP_W-1:0]       s8, max8, min8, d_ext;
    logic                   peak_hit, valley_hit;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = !busy;
    assign accept      = start && !busy;
    assign room        = (r_count < CNT_W'(MAX_SAMPLES));
    assign ram_we      = accept && room;
    assign ram_re      = (r_state == S_RD0) || ((r_state == S_CHECK) && (r_scan < r_count));
    assign ram_raddr   = (r_state == S_RD0) ? '0 : r_scan[ADDR_W-1:0];

    pvd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_sample),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // running extremes including the sample just read
    always_comb begin
        s_val       = ram_rdata;
        upd_max     = r_max;
        upd_max_idx = r_max_idx;
        upd_min     = r_min;
        upd_min_idx = r_min_idx;
        if (s_val > r_max) begin
            upd_max     = s_val;
            upd_max_idx = r_scan[ADDR_W-1:0];
        end
        if (s_val < r_min) begin
            upd_min     = s_val;
            upd_min_idx = r_scan[ADDR_W-1:0];
        end
        s8         = CMP_W'({s_val, pvd_pkg::FRAC_BITS'(0)});
        max8       = CMP_W'({upd_max, pvd_pkg::FRAC_BITS'(0)});
        min8       = CMP_W'({upd_min, pvd_pkg::FRAC_BITS'(0)});
        d_ext      = CMP_W'(r_delta);
        peak_hit   = (s8 + d_ext) < max8;
        valley_hit = s8 > (min8 + d_ext);
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_max        = r_max;
        n_min        = r_min;
        n_max_idx    = r_max_idx;
        n_min_idx    = r_min_idx;
        n_seeking    = r_seeking;
        n_emi_cnt    = r_emi_cnt;
        n_abs_cnt    = r_abs_cnt;
        n_run_status = r_run_status;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_position   = r_position;
        n_status     = r_status;
        n_is_last    = r_is_last;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (room) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = S_RD0;
                    end
                end
            end
            S_RD0: begin
                n_state = S_LD0;
            end
            S_LD0: begin
                n_max        = ram_rdata;
                n_min        = ram_rdata;
                n_max_idx    = '0;
                n_min_idx    = '0;
                n_scan       = CNT_W'(1);
                n_seeking    = r_emission_first;
                n_emi_cnt    = '0;
                n_abs_cnt    = '0;
                n_run_status = pvd_pkg::STATUS_OK;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                n_state = (r_scan < r_count) ? S_EVAL : S_FINISH;
            end
            S_EVAL: begin
                n_max     = upd_max;
                n_max_idx = upd_max_idx;
                n_min     = upd_min;
                n_min_idx = upd_min_idx;
                n_scan    = r_scan + CNT_W'(1);
                n_state   = S_CHECK;
                if (r_seeking && peak_hit) begin
                    if (r_emi_cnt >= r_max_emission) begin
                        n_run_status = pvd_pkg::STATUS_EMISSION_FULL;
                        n_state      = S_FINISH;
                    end else begin
                        n_strobe   = 1'b1;
                        n_kind     = pvd_pkg::KIND_EMISSION;
                        n_position = pvd_pkg::POS_W'(upd_max_idx);
                        n_status   = pvd_pkg::STATUS_OK;
                        n_is_last  = 1'b0;
                        n_emi_cnt  = r_emi_cnt + pvd_pkg::LIMIT_W'(1);
                        n_seeking  = 1'b0;
                        n_scan     = CNT_W'(upd_max_idx);
                        n_min      = upd_max;
                        n_min_idx  = upd_max_idx;
                    end
                end else if (!r_seeking && valley_hit) begin
                    if (r_abs_cnt >= r_max_absorption) begin
                        n_run_status = pvd_pkg::STATUS_ABSORPTION_FULL;
                        n_state      = S_FINISH;
                    end else begin
                        n_strobe   = 1'b1;
                        n_kind     = pvd_pkg::KIND_ABSORPTION;
                        n_position = pvd_pkg::POS_W'(upd_min_idx);
                        n_status   = pvd_pkg::STATUS_OK;
                        n_is_last  = 1'b0;
                        n_abs_cnt  = r_abs_cnt + pvd_pkg::LIMIT_W'(1);
                        n_seeking  = 1'b1;
                        n_scan     = CNT_W'(upd_min_idx);
                        n_max      = upd_min;
                        n_max_idx  = upd_min_idx;
                    end
                end
            end
            S_FINISH: begin
                n_strobe   = 1'b1;
                n_kind     = pvd_pkg::KIND_END;
                n_position = '0;
                n_status   = r_run_status;
                n_is_last  = 1'b1;
                n_count    = '0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_count          <= '0;
            r_strobe         <= 1'b0;
            r_delta          <= pvd_pkg::DELTA_RST;
            r_emission_first <= pvd_pkg::EMISSION_FIRST_RST;
            r_max_emission   <= pvd_pkg::LIMIT_RST;
            r_max_absorption <= pvd_pkg::LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    pvd_pkg::CFG_DELTA: begin
                        r_delta <= i_cfg_data[pvd_pkg::DELTA_W-1:0];
                    end
                    pvd_pkg::CFG_EMISSION_FIRST: begin
                        r_emission_first <= i_cfg_data[0];
                    end
                    pvd_pkg::CFG_MAX_EMISSION: begin
                        r_max_emission <= i_cfg_data[pvd_pkg::LIMIT_W-1:0];
                    end
                    pvd_pkg::CFG_MAX_ABSORPTION: begin
                        r_max_absorption <= i_cfg_data[pvd_pkg::LIMIT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        r_scan       <= n_scan;
        r_max        <= n_max;
        r_min        <= n_min;
        r_max_idx    <= n_max_idx;
        r_min_idx    <= n_min_idx;
        r_seeking    <= n_seeking;
        r_emi_cnt    <= n_emi_cnt;
        r_abs_cnt    <= n_abs_cnt;
        r_run_status <= n_run_status;
        r_kind       <= n_kind;
        r_position   <= n_position;
        r_status     <= n_status;
        r_is_last    <= n_is_last;
    end

    assign o_strobe   = r_strobe;
    assign o_kind     = r_kind;
    assign o_position = r_position;
    assign o_status   = r_status;
    assign o_is_last  = r_is_last;

endmodule

// ===== sv/pvd_checker.sv =====
// ----------------------------------------------------------------------------
// pvd_checker
// port-level checks on the result beats and the busy handshake
// ----------------------------------------------------------------------------
`include "peak_valley_detector_defines.svh"

module pvd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         i_last,
    input logic                         o_strobe,
    input logic [pvd_pkg::KIND_W-1:0]   o_kind,
    input logic [pvd_pkg::POS_W-1:0]    o_position,
    input logic [pvd_pkg::STATUS_W-1:0] o_status,
    input logic                         o_is_last
);

    // the closing beat is the end kind with position zero
    `PVD_ASSERT(a_end_beat, o_strobe && o_is_last |-> o_kind == pvd_pkg::KIND_END && o_position == '0, "end beat malformed")

    // report beats carry ok status and a report kind
    `PVD_ASSERT(a_report_beat, o_strobe && !o_is_last |-> o_status == pvd_pkg::STATUS_OK && (o_kind == pvd_pkg::KIND_EMISSION || o_kind == pvd_pkg::KIND_ABSORPTION), "report beat malformed")

    // a closing sample starts a scan
    `PVD_ASSERT(a_last_starts_scan, start && !busy && i_last |=> busy, "scan not started")

    // a scan only ends together with its end beat
    `PVD_ASSERT(a_scan_ends_with_beat, $past(i_rst_n) && $fell(busy) |-> o_strobe && o_is_last, "scan ended without end beat")

    // results never appear while the block is idle and loading, except the end beat
    `PVD_NEVER(a_no_report_when_idle, o_strobe && !busy && !o_is_last, "report while idle")

endmodule

bind peak_valley_detector pvd_checker u_pvd_checker (.*);

// ===== sim/peak_valley_detector_tb.sv =====
// ----------------------------------------------------------------------------
// peak_valley_detector_tb
// self-checking bench for the delta peak and valley detector
// ----------------------------------------------------------------------------
// Sample sequences are loaded over the start/busy port and closed by a last
// flag. A bench-side copy of the detector state works out the reports and
// the end item that each sequence yields. Every strobed result is checked
// against the oldest pending report. The directed tests cover the threshold
// boundary, both start modes, the list limits, register writes outside the
// map, single-sample and overfull sequences. Random phases then change the
// configuration and send shaped and noisy sequences, with random gaps on the
// sample side outside the third phase.
// ----------------------------------------------------------------------------
module peak_valley_detector_tb;

    localparam int SW            = pvd_pkg::SAMPLE_BITS_DEF;
    localparam int DEPTH         = pvd_pkg::MAX_SAMPLES_DEF;
    localparam int IDX_W         = pvd_pkg::CFG_IDX_W;
    localparam int DATA_W        = pvd_pkg::CFG_DATA_W;
    localparam int KW            = pvd_pkg::KIND_W;
    localparam int PW            = pvd_pkg::POS_W;
    localparam int STW           = pvd_pkg::STATUS_W;
    localparam int DW            = pvd_pkg::DELTA_W;
    localparam int LW            = pvd_pkg::LIMIT_W;
    localparam int FB            = pvd_pkg::FRAC_BITS;
    localparam int RANDOM_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 20;
    localparam int QUIET_LIMIT   = 20000;

    localparam logic [IDX_W-1:0] CFG_UNMAPPED_LOW  = IDX_W'(4);
    localparam logic [IDX_W-1:0] CFG_UNMAPPED_HIGH = '1;

    typedef struct packed {
        logic [KW-1:0]  kind;
        logic [PW-1:0]  position;
        logic [STW-1:0] status;
        logic           is_last;
    } t_report;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    logic [SW-1:0]     i_sample    = '0;
    logic              i_last      = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_data  = '0;
    logic              o_strobe;
    logic [KW-1:0]     o_kind;
    logic [PW-1:0]     o_position;
    logic [STW-1:0]    o_status;
    logic              o_is_last;

    // bench copy of the detector state and registers
    logic [SW-1:0] trace_mem [DEPTH];
    int unsigned   trace_len        = 0;
    logic [DW-1:0] delta_q          = pvd_pkg::DELTA_RST;
    logic          emission_first_q = pvd_pkg::EMISSION_FIRST_RST;
    logic [LW-1:0] max_emission_q   = pvd_pkg::LIMIT_RST;
    logic [LW-1:0] max_absorption_q = pvd_pkg::LIMIT_RST;

    t_report     due_reports [$];
    t_report     seen_rep;
    t_report     due_rep;
    int unsigned mismatch_count = 0;
    int unsigned samples_sent   = 0;
    int unsigned quiet_cycles   = 0;
    bit          steady         = 1'b0;

    peak_valley_detector DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_kind      (o_kind),
        .o_position  (o_position),
        .o_status    (o_status),
        .o_is_last   (o_is_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void expect_report(input logic [KW-1:0] kind,
                                          input int unsigned pos,
                                          input logic [STW-1:0] status,
                                          input logic is_last);
        t_report rep;
        rep.kind     = kind;
        rep.position = pos[PW-1:0];
        rep.status   = status;
        rep.is_last  = is_last;
        due_reports.insert(due_reports.size(), rep);
    endfunction

    // scan the held sequence and queue its reports and end item
    function automatic void find_extrema();
        int unsigned     idx;
        int unsigned     hi_at;
        int unsigned     lo_at;
        int unsigned     n_em;
        int unsigned     n_ab;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned smp;
        longint unsigned thr;
        bit              hunting_peak;
        bit              stopped;
        logic [STW-1:0]  end_status;
        thr          = delta_q;
        end_status   = pvd_pkg::STATUS_OK;
        n_em         = 0;
        n_ab         = 0;
        hunting_peak = emission_first_q;
        stopped      = 1'b0;
        hi_at        = 0;
        lo_at        = 0;
        hi           = trace_mem[0];
        lo           = hi;
        idx          = 1;
        while (idx < trace_len && !stopped) begin
            smp = trace_mem[idx];
            if (smp > hi) begin
                hi    = smp;
                hi_at = idx;
            end
            if (smp < lo) begin
                lo    = smp;
                lo_at = idx;
            end
            if (hunting_peak && (smp << FB) + thr < (hi << FB)) begin
                if (n_em >= max_emission_q) begin
                    end_status = pvd_pkg::STATUS_EMISSION_FULL;
                    stopped    = 1'b1;
                end else begin
                    expect_report(pvd_pkg::KIND_EMISSION, hi_at, pvd_pkg::STATUS_OK, 1'b0);
                    n_em++;
                    hunting_peak = 1'b0;
                    idx          = hi_at;
                    lo           = trace_mem[hi_at];
                    lo_at        = hi_at;
                end
            end else if (!hunting_peak && (smp << FB) > (lo << FB) + thr) begin
                if (n_ab >= max_absorption_q) begin
                    end_status = pvd_pkg::STATUS_ABSORPTION_FULL;
                    stopped    = 1'b1;
                end else begin
                    expect_report(pvd_pkg::KIND_ABSORPTION, lo_at, pvd_pkg::STATUS_OK, 1'b0);
                    n_ab++;
                    hunting_peak = 1'b1;
                    idx          = lo_at;
                    hi           = trace_mem[lo_at];
                    hi_at        = lo_at;
                end
            end else begin
                idx++;
            end
        end
        expect_report(pvd_pkg::KIND_END, 0, end_status, 1'b1);
    endfunction

    function automatic void record_sample(input logic [SW-1:0] value, input logic is_final);
        if (trace_len < DEPTH) begin
            trace_mem[trace_len] = value;
            trace_len++;
        end
        if (is_final) begin
            find_extrema();
            trace_len = 0;
        end
    endfunction

    task automatic send_sample(input logic [SW-1:0] value, input logic is_final);
        while (!steady && $urandom_range(99) < 28) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_sample <= value;
        i_last   <= is_final;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        record_sample(value, is_final);
        samples_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            pvd_pkg::CFG_DELTA:          delta_q          = value[DW-1:0];
            pvd_pkg::CFG_EMISSION_FIRST: emission_first_q = value[0];
            pvd_pkg::CFG_MAX_EMISSION:   max_emission_q   = value[LW-1:0];
            pvd_pkg::CFG_MAX_ABSORPTION: max_absorption_q = value[LW-1:0];
            default: ;
        endcase
    endtask

    task automatic test_single_sample();
        send_sample('1, 1'b1);
    endtask

    task automatic test_both_modes();
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);
        write_reg(pvd_pkg::CFG_EMISSION_FIRST, DATA_W'(0));
        send_sample('1, 1'b0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(SW'(1), 1'b1);
        write_reg(pvd_pkg::CFG_EMISSION_FIRST, DATA_W'(1));
    endtask

    // a fall of exactly delta is not a peak, one step more is
    task automatic test_threshold();
        write_reg(pvd_pkg::CFG_DELTA, DATA_W'(100 << FB));
        send_sample(SW'(1000), 1'b0);
        send_sample(SW'(1100), 1'b0);
        send_sample(SW'(1000), 1'b1);
        write_reg(pvd_pkg::CFG_DELTA, DATA_W'((100 << FB) - 1));
        send_sample(SW'(1000), 1'b0);
        send_sample(SW'(1100), 1'b0);
        send_sample(SW'(1000), 1'b1);
        write_reg(pvd_pkg::CFG_DELTA, '1);
        write_reg(CFG_UNMAPPED_LOW, '0);
        write_reg(CFG_UNMAPPED_HIGH, '0);
        send_sample('0, 1'b0);
        send_sample('1, 1'b0);
        send_sample('0, 1'b1);
        write_reg(pvd_pkg::CFG_DELTA, '0);
    endtask

    task automatic test_list_limits();
        write_reg(pvd_pkg::CFG_MAX_EMISSION, DATA_W'(0));
        send_sample(SW'(0), 1'b0);
        send_sample(SW'(5), 1'b0);
        send_sample(SW'(0), 1'b1);
        write_reg(pvd_pkg::CFG_MAX_EMISSION, DATA_W'(31));
        write_reg(pvd_pkg::CFG_MAX_ABSORPTION, DATA_W'(0));
        write_reg(pvd_pkg::CFG_EMISSION_FIRST, DATA_W'(0));
        send_sample(SW'(5), 1'b0);
        send_sample(SW'(0), 1'b0);
        send_sample(SW'(5), 1'b1);
        write_reg(pvd_pkg::CFG_MAX_ABSORPTION, DATA_W'(31));
        write_reg(pvd_pkg::CFG_EMISSION_FIRST, DATA_W'(1));
    endtask

    // samples past the store depth are dropped, the last one still closes
    task automatic test_store_full();
        int unsigned k;
        logic [SW-1:0] value;
        for (k = 0; k < DEPTH + 6; k++) begin
            if (k == DEPTH - 2)      value = SW'(900);
            else if (k == DEPTH - 1) value = SW'(100);
            else if (k >= DEPTH)     value = '1;
            else                     value = SW'(500);
            send_sample(value, k == DEPTH + 5);
        end
    endtask

    task automatic randomize_config();
        logic [DATA_W-1:0] junk;
        logic [DW-1:0]     new_delta;
        logic [LW-1:0]     limit;
        int unsigned       pick;
        case ($urandom_range(0, 5))
            0:       new_delta = '0;
            1:       new_delta = '1;
            2:       new_delta = DW'($urandom_range(0, 255));
            3:       new_delta = DW'($urandom_range(0, 64 << FB));
            4:       new_delta = DW'($urandom_range(0, 4096 << FB));
            default: new_delta = DW'($urandom());
        endcase
        write_reg(pvd_pkg::CFG_DELTA, new_delta);
        junk = DATA_W'($urandom());
        write_reg(pvd_pkg::CFG_EMISSION_FIRST,
                  {junk[DATA_W-1:1], 1'(($urandom_range(0, 1)))});
        for (pick = 0; pick < 2; pick++) begin
            case ($urandom_range(0, 3))
                0:       limit = '0;
                1:       limit = '1;
                2:       limit = LW'($urandom_range(1, 3));
                default: limit = LW'($urandom_range(0, 31));
            endcase
            junk = DATA_W'($urandom());
            write_reg(pick == 0 ? pvd_pkg::CFG_MAX_EMISSION : pvd_pkg::CFG_MAX_ABSORPTION,
                      {junk[DATA_W-1:LW], limit});
        end
    endtask

    // mostly walks with runs sized against delta, some pure noise
    task automatic send_random_sequence();
        int unsigned len;
        int unsigned step;
        int unsigned span;
        int unsigned k;
        int          level;
        bit          noisy;
        bit          rising;
        noisy = ($urandom_range(0, 9) == 0);
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                            : $urandom_range(1, 40);
        span  = (delta_q >> FB) + 1;
        case ($urandom_range(0, 3))
            0:       step = span / 4 + 1;
            1:       step = span;
            2:       step = 2 * span;
            default: step = $urandom_range(1, 65535);
        endcase
        if (step > 65535) step = 65535;
        level  = int'($urandom_range(0, 65535));
        rising = $urandom_range(0, 1);
        for (k = 0; k < len; k++) begin
            if (noisy) begin
                level = int'($urandom_range(0, 65535));
            end else begin
                if ($urandom_range(0, 4) == 0) rising = !rising;
                if (rising) level = level + int'($urandom_range(0, step));
                else        level = level - int'($urandom_range(0, step));
                if (level > 65535) begin
                    level  = 65535;
                    rising = 1'b0;
                end
                if (level < 0) begin
                    level  = 0;
                    rising = 1'b1;
                end
            end
            send_sample(SW'(level), k == len - 1);
        end
    endtask

    task automatic test_random_sequences();
        int unsigned stop_at;
        int unsigned phase_end;
        int unsigned phase;
        stop_at = samples_sent + RANDOM_ITEMS;
        phase   = 0;
        while (samples_sent < stop_at) begin
            randomize_config();
            steady    = (phase == 2);
            phase_end = samples_sent + $urandom_range(40, 80);
            while (samples_sent < phase_end && samples_sent < stop_at)
                send_random_sequence();
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen_rep.kind     = o_kind;
            seen_rep.position = o_position;
            seen_rep.status   = o_status;
            seen_rep.is_last  = o_is_last;
            if (due_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d pos %0d status %0d last %0b",
                             o_kind, o_position, o_status, o_is_last);
            end else begin
                due_rep = due_reports.pop_front();
                if (seen_rep.kind !== due_rep.kind ||
                    seen_rep.position !== due_rep.position ||
                    seen_rep.status !== due_rep.status ||
                    seen_rep.is_last !== due_rep.is_last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected kind %0d pos %0d status %0d last %0b,",
                                  " got kind %0d pos %0d status %0d last %0b"},
                                 due_rep.kind, due_rep.position, due_rep.status,
                                 due_rep.is_last, seen_rep.kind, seen_rep.position,
                                 seen_rep.status, seen_rep.is_last);
                end
            end
        end
    end

    // no beat on any port for too long ends the run
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_single_sample();
        test_both_modes();
        test_threshold();
        test_list_limits();
        test_store_full();
        test_random_sequences();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && due_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
